// ===== src/wsdf_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared widths and header constants for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned OpW     = 4;
    localparam int unsigned LenW    = 64;
    localparam int unsigned KeyW    = 32;
    localparam int unsigned CountW  = 3;
    localparam int unsigned UserW   = OpW + 2;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [CountW-1:0] EXT16_BYTES_LEFT = 3'd1;
    localparam logic [CountW-1:0] EXT64_BYTES_LEFT = 3'd7;
    localparam logic [CountW-1:0] KEY_BYTES_LEFT   = 3'd3;

endpackage

// ===== src/websocket_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer unit
// Parses the headers of a back-to-back stream of WebSocket frames and emits
// the unmasked payload bytes with the frame opcode and fin bit.
// ----------------------------------------------------------------------------
// A payload byte appears on the output register in the cycle after it is
// accepted. One byte per cycle unless the output stalls, limited by the single
// parse step between the input port and the output register. Reset clears the
// parser to the first header byte and empties the output register.
module websocket_frame_deframer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [wsdf_pkg::ByteW-1:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [wsdf_pkg::ByteW-1:0]  m_axis_tdata,   // [7:0] data_byte
    output logic                        m_axis_tlast,   // last_byte
    output logic [wsdf_pkg::UserW-1:0]  m_axis_tuser    // [3:0] frame_opcode,
                                                        // [4] final_fragment,
                                                        // [5] empty_frame
);

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic [wsdf_pkg::CountW-1:0]     r_count, n_count;
    logic [wsdf_pkg::LenW-1:0]       r_remaining, n_remaining;
    logic [wsdf_pkg::KeyW-1:0]       r_key, n_key;
    logic                            r_mask_en, n_mask_en;
    logic [1:0]                      r_key_idx, n_key_idx;
    logic [wsdf_pkg::OpW-1:0]        r_opcode, n_opcode;
    logic                            r_fin, n_fin;

    logic                            r_out_valid;
    logic [wsdf_pkg::ByteW-1:0]      r_out_data;
    logic                            r_out_last;
    logic                            r_out_empty;
    logic [wsdf_pkg::OpW-1:0]        r_out_opcode;
    logic                            r_out_fin;

    logic                            accept;
    logic                            emit;
    logic [wsdf_pkg::ByteW-1:0]      emit_data;
    logic                            emit_last;
    logic                            emit_empty;
    logic                            length_done;
    logic                            begin_payload;
    logic [6:0]                      len7;
    logic [wsdf_pkg::ByteW-1:0]      key_byte;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        unique case (r_key_idx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase       = r_phase;
        n_count       = r_count;
        n_remaining   = r_remaining;
        n_key         = r_key;
        n_mask_en     = r_mask_en;
        n_key_idx     = r_key_idx;
        n_opcode      = r_opcode;
        n_fin         = r_fin;
        emit          = 1'b0;
        emit_data     = '0;
        emit_last     = 1'b0;
        emit_empty    = 1'b0;
        length_done   = 1'b0;
        begin_payload = 1'b0;
        len7          = s_axis_tdata[6:0];

        unique case (r_phase)
            PH_HDR1: begin
                n_mask_en   = s_axis_tdata[7];
                n_remaining = '0;
                if (len7 == wsdf_pkg::LEN_EXT16) begin
                    n_phase = PH_EXTLEN;
                    n_count = wsdf_pkg::EXT16_BYTES_LEFT;
                end else if (len7 == wsdf_pkg::LEN_EXT64) begin
                    n_phase = PH_EXTLEN;
                    n_count = wsdf_pkg::EXT64_BYTES_LEFT;
                end else begin
                    n_remaining = {{(wsdf_pkg::LenW-7){1'b0}}, len7};
                    length_done = 1'b1;
                end
            end
            PH_EXTLEN: begin
                n_remaining = {r_remaining[wsdf_pkg::LenW-9:0], s_axis_tdata};
                if (r_count == '0) begin
                    length_done = 1'b1;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            PH_KEY: begin
                n_key = {r_key[wsdf_pkg::KeyW-9:0], s_axis_tdata};
                if (r_count == '0) begin
                    begin_payload = 1'b1;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            PH_PAYLOAD: begin
                emit        = 1'b1;
                emit_data   = s_axis_tdata ^ (r_mask_en ? key_byte : '0);
                n_key_idx   = r_key_idx + 1'b1;
                n_remaining = r_remaining - 1'b1;
                emit_last   = (r_remaining == {{(wsdf_pkg::LenW-1){1'b0}}, 1'b1});
                if (emit_last) begin
                    n_phase = PH_HDR0;
                end
            end
            default: begin
                n_fin    = s_axis_tdata[7];
                n_opcode = s_axis_tdata[wsdf_pkg::OpW-1:0];
                n_phase  = PH_HDR1;
            end
        endcase

        if (length_done) begin
            if (n_mask_en) begin
                n_phase = PH_KEY;
                n_count = wsdf_pkg::KEY_BYTES_LEFT;
                n_key   = '0;
            end else begin
                begin_payload = 1'b1;
            end
        end

        if (begin_payload) begin
            n_key_idx = '0;
            if (n_remaining == '0) begin
                n_phase    = PH_HDR0;
                emit       = 1'b1;
                emit_last  = 1'b1;
                emit_empty = 1'b1;
            end else begin
                n_phase = PH_PAYLOAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR0;
            r_count     <= '0;
            r_remaining <= '0;
            r_key       <= '0;
            r_mask_en   <= 1'b0;
            r_key_idx   <= '0;
            r_opcode    <= '0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_count     <= n_count;
                r_remaining <= n_remaining;
                r_key       <= n_key;
                r_mask_en   <= n_mask_en;
                r_key_idx   <= n_key_idx;
                r_opcode    <= n_opcode;
                r_fin       <= n_fin;
            end
            if (accept && emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out_data   <= emit_data;
            r_out_last   <= emit_last;
            r_out_empty  <= emit_empty;
            r_out_opcode <= r_opcode;
            r_out_fin    <= r_fin;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = {r_out_empty, r_out_fin, r_out_opcode};

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_empty |-> r_out_last && (r_out_data == '0))
        else $error("Empty-frame marker without last flag or with nonzero data.");

    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_remaining != '0)
        else $error("Payload phase entered with no bytes remaining.");

    a_key_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_KEY |-> r_count <= wsdf_pkg::KEY_BYTES_LEFT)
        else $error("Mask key byte count out of range.");

    a_reset_phase: assert property (@(posedge i_clk)
        !i_rst_n |=> r_phase == PH_HDR0 && !r_out_valid)
        else $error("Parser not at first header byte after reset.");

    a_no_load_while_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |-> !accept)
        else $error("Input accepted while a result is stalled.");

endmodule

// ===== verif/websocket_frame_deframer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket deframer checker
// Watches the byte input and the payload output of the deframer. It parses
// every accepted input transaction with its own header parser, queues the
// payload results that the parser predicts, and compares every accepted
// output transaction with the oldest queued result.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_rx_tvalid,
    input  logic                                i_rx_tready,
    input  logic [wsdf_pkg::ByteW-1:0]          i_rx_tdata,    // [7:0] rx_byte
    input  logic                                i_pl_tvalid,
    input  logic                                i_pl_tready,
    input  logic [wsdf_pkg::ByteW-1:0]          i_pl_tdata,    // [7:0] data_byte
    input  logic                                i_pl_tlast,    // last_byte
    input  logic [wsdf_pkg::UserW-1:0]          i_pl_tuser,    // [3:0] frame_opcode,
                                                               // [4] final_fragment,
                                                               // [5] empty_frame
    output int                                  o_fail_count,
    output int                                  o_pending
);

    typedef enum logic [2:0] {
        HDR_FIRST,
        HDR_LENGTH,
        HDR_EXT_LENGTH,
        HDR_MASK_KEY,
        PAYLOAD
    } t_parse_phase;

    typedef struct packed {
        logic [wsdf_pkg::ByteW-1:0] data;
        logic                       last;
        logic [wsdf_pkg::OpW-1:0]   opcode;
        logic                       fin;
        logic                       empty;
    } t_payload;

    t_payload                       payload_q[$];
    int                             mismatches = 0;

    t_parse_phase                   phase;
    logic [wsdf_pkg::CountW-1:0]    hdr_left;
    logic [wsdf_pkg::LenW-1:0]      bytes_left;
    logic [wsdf_pkg::KeyW-1:0]      mask_key;
    logic                           masked;
    logic [1:0]                     key_pos;
    logic [wsdf_pkg::OpW-1:0]       frame_opcode;
    logic                           frame_fin;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    task reset_parser();
        phase = HDR_FIRST;
        hdr_left = '0;
        bytes_left = '0;
        mask_key = '0;
        masked = 1'b0;
        key_pos = '0;
        frame_opcode = '0;
        frame_fin = 1'b0;
    endtask

    task push_payload(input logic [wsdf_pkg::ByteW-1:0] data, input logic last,
                      input logic empty);
        t_payload r;
        r.data = data;
        r.last = last;
        r.opcode = frame_opcode;
        r.fin = frame_fin;
        r.empty = empty;
        payload_q.insert(payload_q.size(), r);
    endtask

    // Once the header is complete, a zero length frame yields the empty marker.
    task enter_payload();
        key_pos = '0;
        if (bytes_left == '0) begin
            phase = HDR_FIRST;
            push_payload('0, 1'b1, 1'b1);
        end else begin
            phase = PAYLOAD;
        end
    endtask

    task length_known();
        if (masked) begin
            phase = HDR_MASK_KEY;
            hdr_left = wsdf_pkg::KEY_BYTES_LEFT;
            mask_key = '0;
        end else begin
            enter_payload();
        end
    endtask

    task parse_rx_byte(input logic [wsdf_pkg::ByteW-1:0] b);
        logic [wsdf_pkg::ByteW-1:0] d;
        case (phase)
            HDR_LENGTH: begin
                masked = b[7];
                bytes_left = '0;
                if (b[6:0] == wsdf_pkg::LEN_EXT16) begin
                    phase = HDR_EXT_LENGTH;
                    hdr_left = wsdf_pkg::EXT16_BYTES_LEFT;
                end else if (b[6:0] == wsdf_pkg::LEN_EXT64) begin
                    phase = HDR_EXT_LENGTH;
                    hdr_left = wsdf_pkg::EXT64_BYTES_LEFT;
                end else begin
                    bytes_left = wsdf_pkg::LenW'(b[6:0]);
                    length_known();
                end
            end
            HDR_EXT_LENGTH: begin
                bytes_left = {bytes_left[wsdf_pkg::LenW-wsdf_pkg::ByteW-1:0], b};
                if (hdr_left == '0) begin
                    length_known();
                end else begin
                    hdr_left = hdr_left - 1'b1;
                end
            end
            HDR_MASK_KEY: begin
                mask_key = {mask_key[wsdf_pkg::KeyW-wsdf_pkg::ByteW-1:0], b};
                if (hdr_left == '0) begin
                    enter_payload();
                end else begin
                    hdr_left = hdr_left - 1'b1;
                end
            end
            PAYLOAD: begin
                d = b;
                if (masked) begin
                    d = b ^ mask_key[(3 - key_pos) * wsdf_pkg::ByteW +: wsdf_pkg::ByteW];
                end
                key_pos = key_pos + 1'b1;
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == '0) begin
                    phase = HDR_FIRST;
                end
                push_payload(d, bytes_left == '0, 1'b0);
            end
            default: begin
                frame_fin = b[7];
                frame_opcode = b[wsdf_pkg::OpW-1:0];
                phase = HDR_LENGTH;
            end
        endcase
    endtask

    task check_payload();
        t_payload want;
        t_payload got;
        got = {i_pl_tdata, i_pl_tlast, i_pl_tuser[wsdf_pkg::OpW-1:0],
               i_pl_tuser[wsdf_pkg::OpW], i_pl_tuser[wsdf_pkg::OpW+1]};
        if (payload_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected payload transaction expected none, actual",
                     $time);
            $display("%0t:   data=%02h last=%0b op=%h fin=%0b empty=%0b",
                     $time, got.data, got.last, got.opcode, got.fin, got.empty);
        end else begin
            want = payload_q.pop_front();
            if (got !== want) begin
                mismatches++;
                $display("%0t: payload mismatch expected data=%02h last=%0b op=%h fin=%0b empty=%0b",
                         $time, want.data, want.last, want.opcode, want.fin, want.empty);
                $display("%0t:                  actual   data=%02h last=%0b op=%h fin=%0b empty=%0b",
                         $time, got.data, got.last, got.opcode, got.fin, got.empty);
            end
        end
    endtask

    // The output is registered, so a result leaving at this edge always belongs
    // to an earlier input transaction; check it before parsing the new byte.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_parser();
            payload_q.delete();
        end else begin
            if (i_pl_tvalid && i_pl_tready) begin
                check_payload();
            end
            if (i_rx_tvalid && i_rx_tready) begin
                parse_rx_byte(i_rx_tdata);
            end
        end
        o_fail_count <= mismatches;
        o_pending <= payload_q.size();
    end

endmodule

// ===== verif/websocket_frame_deframer_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket deframer testbench
// Feeds the deframer a byte stream of WebSocket frames: a few directed frames
// with empty payloads, extended lengths and masking, then random frames of
// every header form, and finally a frame with a huge 64-bit length. The
// sender works in bursts and the receiver stalls in changing patterns. A
// checker beside the block predicts and compares the payload transactions.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit_tb;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int          STREAM_BYTES = 450;
    localparam int          DRAIN_CYCLES = 20;

    typedef enum logic [1:0] {
        LEN_SHORT,
        LEN_16BIT,
        LEN_64BIT
    } t_len_form;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_PERIODIC,
        RDY_SPARSE
    } t_ready_mode;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [wsdf_pkg::ByteW-1:0]         s_axis_tdata = '0;     // [7:0] rx_byte
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [wsdf_pkg::ByteW-1:0]         m_axis_tdata;          // [7:0] data_byte
    logic                               m_axis_tlast;          // last_byte
    logic [wsdf_pkg::UserW-1:0]         m_axis_tuser;          // [3:0] frame_opcode,
                                                               // [4] final_fragment,
                                                               // [5] empty_frame

    int                                 fail_count;
    int                                 pending;
    int unsigned                        cycle_count = 0;
    t_ready_mode                        ready_mode = RDY_ALWAYS;
    int                                 mode_left = 0;
    int                                 burst_left = 0;
    logic [wsdf_pkg::ByteW-1:0]         rx_stream[$];

    websocket_frame_deframer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    websocket_frame_deframer_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_tvalid  (s_axis_tvalid),
        .i_rx_tready  (s_axis_tready),
        .i_rx_tdata   (s_axis_tdata),
        .i_pl_tvalid  (m_axis_tvalid),
        .i_pl_tready  (m_axis_tready),
        .i_pl_tdata   (m_axis_tdata),
        .i_pl_tlast   (m_axis_tlast),
        .i_pl_tuser   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // The receiver switches between randomly chosen stall patterns.
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode <= t_ready_mode'($urandom_range(0, 3));
            mode_left <= $urandom_range(20, 120);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            RDY_ALWAYS:   m_axis_tready <= 1'b1;
            RDY_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
            RDY_PERIODIC: m_axis_tready <= (cycle_count % 3) != 0;
            default:      m_axis_tready <= $urandom_range(0, 7) == 0;
        endcase
    end

    task put_byte(input logic [wsdf_pkg::ByteW-1:0] b);
        rx_stream.insert(rx_stream.size(), b);
    endtask

    task add_frame(input logic fin, input logic [2:0] rsv,
                   input logic [wsdf_pkg::OpW-1:0] opcode, input logic masked,
                   input t_len_form form, input logic [wsdf_pkg::LenW-1:0] len,
                   input logic [wsdf_pkg::KeyW-1:0] key, input int sent_len);
        put_byte({fin, rsv, opcode});
        case (form)
            LEN_16BIT: begin
                put_byte({masked, wsdf_pkg::LEN_EXT16});
                put_byte(len[15:8]);
                put_byte(len[7:0]);
            end
            LEN_64BIT: begin
                put_byte({masked, wsdf_pkg::LEN_EXT64});
                for (int i = 7; i >= 0; i--) begin
                    put_byte(len[i * wsdf_pkg::ByteW +: wsdf_pkg::ByteW]);
                end
            end
            default: put_byte({masked, len[6:0]});
        endcase
        if (masked) begin
            for (int i = 3; i >= 0; i--) begin
                put_byte(key[i * wsdf_pkg::ByteW +: wsdf_pkg::ByteW]);
            end
        end
        repeat (sent_len) put_byte(wsdf_pkg::ByteW'($urandom_range(0, 255)));
    endtask

    task send_byte(input logic [wsdf_pkg::ByteW-1:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
    endtask

    initial begin
        int                             frames;
        int                             pick;
        t_len_form                      form;
        logic [wsdf_pkg::LenW-1:0]      len;
        logic [wsdf_pkg::OpW-1:0]       opcode;

        add_frame(1'b1, 3'd0, 4'h1, 1'b0, LEN_SHORT, 64'd0, 32'h0, 0);
        add_frame(1'b1, 3'd0, 4'h2, 1'b0, LEN_SHORT, 64'd3, 32'h0, 3);
        add_frame(1'b0, 3'd7, 4'hF, 1'b1, LEN_SHORT, 64'd5, 32'hFF00A53C, 5);
        add_frame(1'b1, 3'd0, 4'h8, 1'b0, LEN_16BIT, 64'd0, 32'h0, 0);
        add_frame(1'b1, 3'd2, 4'hA, 1'b1, LEN_SHORT, 64'd0, 32'h5AC3_0FF0, 0);

        frames = 0;
        while (rx_stream.size() < STREAM_BYTES) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                form = LEN_SHORT;
                len = ($urandom_range(0, 9) == 0) ?
                      wsdf_pkg::LenW'($urandom_range(0, 125)) :
                      wsdf_pkg::LenW'($urandom_range(0, 12));
            end else if (pick < 8) begin
                form = LEN_16BIT;
                len = ($urandom_range(0, 7) == 0) ?
                      wsdf_pkg::LenW'($urandom_range(126, 300)) :
                      wsdf_pkg::LenW'($urandom_range(0, 20));
            end else begin
                form = LEN_64BIT;
                len = wsdf_pkg::LenW'($urandom_range(0, 16));
            end
            opcode = (frames < 16) ? wsdf_pkg::OpW'(frames) :
                                     wsdf_pkg::OpW'($urandom_range(0, 15));
            add_frame(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), opcode,
                      1'($urandom_range(0, 1)), form, len,
                      wsdf_pkg::KeyW'($urandom), int'(len));
            frames++;
        end

        // The top bit of a 64-bit length is taken as part of the length; this
        // frame never ends within the run.
        add_frame(1'b1, 3'd0, 4'h2, 1'b1, LEN_64BIT, {1'b1, 31'd0, 32'($urandom)},
                  wsdf_pkg::KeyW'($urandom), 6);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rx_stream[i]) begin
            send_byte(rx_stream[i]);
        end
        s_axis_tvalid <= 1'b0;

        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== websocket_frame_deframer_unit.f =====
src/wsdf_pkg.sv
src/websocket_frame_deframer_unit.sv
verif/websocket_frame_deframer_checker.sv
verif/websocket_frame_deframer_unit_tb.sv
